/* src/jvmexe_pkg.sv */
// Shared types, opcodes and status codes of the JVM integer execute core.
`timescale 1ns / 1ps

package jvmexe_pkg;

  localparam int STACK_SLOTS_DEF = 64;
  localparam int LOCAL_SLOTS_DEF = 256;

  typedef struct packed {
    logic [7:0]         req_type;
    logic signed [15:0] immediate;
    logic signed [7:0]  increment;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               branch_taken;
    logic signed [15:0] branch_offset;
    logic [6:0]         stack_depth;
    logic signed [31:0] top_value;
  } out_item_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNSUP   = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;
  localparam logic [1:0] ST_FAULT   = 2'd3;

  localparam logic [1:0] MD_MUL = 2'd0;
  localparam logic [1:0] MD_DIV = 2'd1;
  localparam logic [1:0] MD_REM = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] a;
    logic [63:0] b;
  } md_req_t;

  localparam logic [7:0] OP_NOP         = 8'h00;
  localparam logic [7:0] OP_ACONST_NULL = 8'h01;
  localparam logic [7:0] OP_ICONST_M1   = 8'h02;
  localparam logic [7:0] OP_ICONST_0    = 8'h03;
  localparam logic [7:0] OP_ICONST_1    = 8'h04;
  localparam logic [7:0] OP_ICONST_2    = 8'h05;
  localparam logic [7:0] OP_ICONST_3    = 8'h06;
  localparam logic [7:0] OP_ICONST_4    = 8'h07;
  localparam logic [7:0] OP_ICONST_5    = 8'h08;
  localparam logic [7:0] OP_LCONST_0    = 8'h09;
  localparam logic [7:0] OP_LCONST_1    = 8'h0A;
  localparam logic [7:0] OP_BIPUSH      = 8'h10;
  localparam logic [7:0] OP_SIPUSH      = 8'h11;
  localparam logic [7:0] OP_ILOAD       = 8'h15;
  localparam logic [7:0] OP_LLOAD       = 8'h16;
  localparam logic [7:0] OP_ALOAD       = 8'h19;
  localparam logic [7:0] OP_ILOAD_0     = 8'h1A;
  localparam logic [7:0] OP_ILOAD_1     = 8'h1B;
  localparam logic [7:0] OP_ILOAD_2     = 8'h1C;
  localparam logic [7:0] OP_ILOAD_3     = 8'h1D;
  localparam logic [7:0] OP_LLOAD_0     = 8'h1E;
  localparam logic [7:0] OP_LLOAD_1     = 8'h1F;
  localparam logic [7:0] OP_LLOAD_2     = 8'h20;
  localparam logic [7:0] OP_LLOAD_3     = 8'h21;
  localparam logic [7:0] OP_ALOAD_0     = 8'h2A;
  localparam logic [7:0] OP_ALOAD_1     = 8'h2B;
  localparam logic [7:0] OP_ALOAD_2     = 8'h2C;
  localparam logic [7:0] OP_ALOAD_3     = 8'h2D;
  localparam logic [7:0] OP_ISTORE      = 8'h36;
  localparam logic [7:0] OP_LSTORE      = 8'h37;
  localparam logic [7:0] OP_ASTORE      = 8'h3A;
  localparam logic [7:0] OP_ISTORE_0    = 8'h3B;
  localparam logic [7:0] OP_ISTORE_1    = 8'h3C;
  localparam logic [7:0] OP_ISTORE_2    = 8'h3D;
  localparam logic [7:0] OP_ISTORE_3    = 8'h3E;
  localparam logic [7:0] OP_LSTORE_0    = 8'h3F;
  localparam logic [7:0] OP_LSTORE_1    = 8'h40;
  localparam logic [7:0] OP_LSTORE_2    = 8'h41;
  localparam logic [7:0] OP_LSTORE_3    = 8'h42;
  localparam logic [7:0] OP_ASTORE_0    = 8'h4B;
  localparam logic [7:0] OP_ASTORE_1    = 8'h4C;
  localparam logic [7:0] OP_ASTORE_2    = 8'h4D;
  localparam logic [7:0] OP_ASTORE_3    = 8'h4E;
  localparam logic [7:0] OP_POP         = 8'h57;
  localparam logic [7:0] OP_POP2        = 8'h58;
  localparam logic [7:0] OP_DUP         = 8'h59;
  localparam logic [7:0] OP_DUP2        = 8'h5C;
  localparam logic [7:0] OP_SWAP        = 8'h5F;
  localparam logic [7:0] OP_IADD        = 8'h60;
  localparam logic [7:0] OP_LADD        = 8'h61;
  localparam logic [7:0] OP_ISUB        = 8'h64;
  localparam logic [7:0] OP_LSUB        = 8'h65;
  localparam logic [7:0] OP_IMUL        = 8'h68;
  localparam logic [7:0] OP_LMUL        = 8'h69;
  localparam logic [7:0] OP_IDIV        = 8'h6C;
  localparam logic [7:0] OP_LDIV        = 8'h6D;
  localparam logic [7:0] OP_IREM        = 8'h70;
  localparam logic [7:0] OP_LREM        = 8'h71;
  localparam logic [7:0] OP_INEG        = 8'h74;
  localparam logic [7:0] OP_LNEG        = 8'h75;
  localparam logic [7:0] OP_ISHL        = 8'h78;
  localparam logic [7:0] OP_LSHL        = 8'h79;
  localparam logic [7:0] OP_ISHR        = 8'h7A;
  localparam logic [7:0] OP_LSHR        = 8'h7B;
  localparam logic [7:0] OP_IUSHR       = 8'h7C;
  localparam logic [7:0] OP_LUSHR       = 8'h7D;
  localparam logic [7:0] OP_IAND        = 8'h7E;
  localparam logic [7:0] OP_LAND        = 8'h7F;
  localparam logic [7:0] OP_IOR         = 8'h80;
  localparam logic [7:0] OP_LOR         = 8'h81;
  localparam logic [7:0] OP_IXOR        = 8'h82;
  localparam logic [7:0] OP_LXOR        = 8'h83;
  localparam logic [7:0] OP_IINC        = 8'h84;
  localparam logic [7:0] OP_I2L         = 8'h85;
  localparam logic [7:0] OP_L2I         = 8'h88;
  localparam logic [7:0] OP_I2B         = 8'h91;
  localparam logic [7:0] OP_I2C         = 8'h92;
  localparam logic [7:0] OP_I2S         = 8'h93;
  localparam logic [7:0] OP_LCMP        = 8'h94;
  localparam logic [7:0] OP_IFEQ        = 8'h99;
  localparam logic [7:0] OP_IFNE        = 8'h9A;
  localparam logic [7:0] OP_IFLT        = 8'h9B;
  localparam logic [7:0] OP_IFGE        = 8'h9C;
  localparam logic [7:0] OP_IFGT        = 8'h9D;
  localparam logic [7:0] OP_IFLE        = 8'h9E;
  localparam logic [7:0] OP_IF_ICMPEQ   = 8'h9F;
  localparam logic [7:0] OP_IF_ICMPNE   = 8'hA0;
  localparam logic [7:0] OP_IF_ICMPLT   = 8'hA1;
  localparam logic [7:0] OP_IF_ICMPGE   = 8'hA2;
  localparam logic [7:0] OP_IF_ICMPGT   = 8'hA3;
  localparam logic [7:0] OP_IF_ICMPLE   = 8'hA4;
  localparam logic [7:0] OP_IF_ACMPEQ   = 8'hA5;
  localparam logic [7:0] OP_IF_ACMPNE   = 8'hA6;
  localparam logic [7:0] OP_GOTO        = 8'hA7;

endpackage

/* src/jvmexe_muldiv.sv */
// Iterative 64-bit multiplier and signed divider, one bit per cycle.
`timescale 1ns / 1ps

module jvmexe_muldiv (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  jvmexe_pkg::md_req_t req,
  output logic                busy,
  output logic                done,
  output logic [63:0]         result
);

  logic [63:0] acc_r;
  logic [63:0] x_r;
  logic [63:0] y_r;
  logic [5:0]  cnt_r;
  logic [1:0]  op_r;
  logic        qneg_r;
  logic        rneg_r;
  logic        busy_r;
  logic        done_r;
  logic [64:0] trial;
  logic [63:0] ua;
  logic [63:0] ub;

  assign ua    = req.a[63] ? 64'd0 - req.a : req.a;
  assign ub    = req.b[63] ? 64'd0 - req.b : req.b;
  assign trial = {acc_r, x_r[63]} - {1'b0, y_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        op_r   <= req.op;
        acc_r  <= '0;
        qneg_r <= req.a[63] ^ req.b[63];
        rneg_r <= req.a[63];
        if (req.op == jvmexe_pkg::MD_MUL) begin
          x_r <= req.b;
          y_r <= req.a;
        end else begin
          x_r <= ua;
          y_r <= ub;
        end
      end else if (busy_r) begin
        if (op_r == jvmexe_pkg::MD_MUL) begin
          if (x_r[0]) acc_r <= acc_r + y_r;
          y_r <= {y_r[62:0], 1'b0};
          x_r <= {1'b0, x_r[63:1]};
        end else if (!trial[64]) begin
          acc_r <= trial[63:0];
          x_r   <= {x_r[62:0], 1'b1};
        end else begin
          acc_r <= {acc_r[62:0], x_r[63]};
          x_r   <= {x_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    unique case (op_r)
      jvmexe_pkg::MD_DIV: result = qneg_r ? 64'd0 - x_r : x_r;
      jvmexe_pkg::MD_REM: result = rneg_r ? 64'd0 - acc_r : acc_r;
      default:            result = acc_r;
    endcase
  end

  assign busy = busy_r;
  assign done = done_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("done without a running operation");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r))
    else $error("busy and done together");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("start while busy");

endmodule

/* src/jvm_integer_bytecode_execute_core.sv */
// Top level of the JVM integer bytecode execute core.
// Usage:
//   in channel (in_valid/in_ready/in_data): one opcode with its immediate and
//   increment per transaction. out channel (out_valid/out_ready/out_data): one
//   result per transaction with status, branch decision and offset, stack
//   depth and top slot.
//   One instruction is worked on at a time. From acceptance to result it reads
//   the operand stack memory and the local slot memory (one synchronous read
//   port each), executes, writes the pushed slots to the stack and the stored
//   slots to the local memory, and loads the output register. imul, idiv, irem,
//   lmul, ldiv and lrem also wait on the bit-serial multiply/divide unit, except
//   on a zero divisor. A new instruction is accepted only after the last one
//   has loaded the output register.
//   The output register holds a result until out_ready; the next instruction
//   is accepted while it waits, and its own result waits until the register
//   frees up.
//   Reset (rst_n low at a clock edge) empties the stack and marks all local
//   slots as zero at once; no clearing pass is needed.
`timescale 1ns / 1ps

module jvm_integer_bytecode_execute_core #(
  parameter int STACK_SLOTS = jvmexe_pkg::STACK_SLOTS_DEF,
  parameter int LOCAL_SLOTS = jvmexe_pkg::LOCAL_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  jvmexe_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output jvmexe_pkg::out_item_t out_data
);

  localparam int SPW = $clog2(STACK_SLOTS + 1);
  localparam int AW  = $clog2(STACK_SLOTS);
  localparam int LW  = $clog2(LOCAL_SLOTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EX   = 3'd2;
  localparam logic [2:0] S_MD   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]     state_r;
  logic [7:0]     op_r;
  logic [15:0]    imm_r;
  logic [7:0]     inc_r;
  logic [LW-1:0]  lidx_r;
  logic [LW-1:0]  lidx1;
  logic [SPW-1:0] sp_r;
  logic [SPW-1:0] base_r;
  logic [2:0]     rc_r;
  logic [1:0]     wc_r;
  logic [31:0]    opnd_r [4];
  logic [31:0]    lcl0_r;
  logic [31:0]    lcl1_r;
  logic [31:0]    res_r [4];
  logic [31:0]    lwv_r [2];
  logic [2:0]     npop_r;
  logic [2:0]     npush_r;
  logic [1:0]     nlw_r;
  logic [1:0]     status_r;
  logic           taken_r;
  logic           md_long_r;
  logic           out_valid_r;
  jvmexe_pkg::out_item_t out_r;

  logic [31:0]    smem [STACK_SLOTS];
  logic [31:0]    srd_r;
  logic           srv_r;
  logic [31:0]    lmem [LOCAL_SLOTS];
  logic [LOCAL_SLOTS-1:0] lvalid_r;
  logic [31:0]    lrd_r;
  logic           lrv_r;

  logic [LW-1:0]  mod_tab [256];
  logic [7:0]     idx8;
  logic [AW-1:0]  s_raddr;
  logic [AW-1:0]  s_waddr;
  logic           s_we;
  logic [LW-1:0]  l_raddr;
  logic [LW-1:0]  l_waddr;
  logic           l_we;
  logic [2:0]     nwr;

  logic [31:0]    a;
  logic [31:0]    b;
  logic [63:0]    la;
  logic [63:0]    lb;
  logic [63:0]    lr;
  logic [63:0]    lsv;
  logic           unsup;
  logic [2:0]     npop;
  logic [2:0]     npush;
  logic [1:0]     nlw;
  logic [31:0]    r [4];
  logic [31:0]    lwv0;
  logic [31:0]    lwv1;
  logic           isbr;
  logic           cond;
  logic           md_use;
  logic [1:0]     md_op;
  logic           md_long;
  logic           dz;
  logic           fits;
  logic [SPW:0]   sp_after;
  logic           md_start;
  logic           md_busy;
  logic           md_done;
  logic [63:0]    md_res;
  jvmexe_pkg::md_req_t md_req;
  logic           out_load;
  logic [31:0]    top;

  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tab[g] = LW'(g % LOCAL_SLOTS);
  end

  always_comb begin
    priority if (in_data.req_type >= jvmexe_pkg::OP_ILOAD_0 &&
                 in_data.req_type <= jvmexe_pkg::OP_ILOAD_3)
      idx8 = in_data.req_type - jvmexe_pkg::OP_ILOAD_0;
    else if (in_data.req_type >= jvmexe_pkg::OP_LLOAD_0 &&
             in_data.req_type <= jvmexe_pkg::OP_LLOAD_3)
      idx8 = in_data.req_type - jvmexe_pkg::OP_LLOAD_0;
    else if (in_data.req_type >= jvmexe_pkg::OP_ALOAD_0 &&
             in_data.req_type <= jvmexe_pkg::OP_ALOAD_3)
      idx8 = in_data.req_type - jvmexe_pkg::OP_ALOAD_0;
    else if (in_data.req_type >= jvmexe_pkg::OP_ISTORE_0 &&
             in_data.req_type <= jvmexe_pkg::OP_ISTORE_3)
      idx8 = in_data.req_type - jvmexe_pkg::OP_ISTORE_0;
    else if (in_data.req_type >= jvmexe_pkg::OP_LSTORE_0 &&
             in_data.req_type <= jvmexe_pkg::OP_LSTORE_3)
      idx8 = in_data.req_type - jvmexe_pkg::OP_LSTORE_0;
    else if (in_data.req_type >= jvmexe_pkg::OP_ASTORE_0 &&
             in_data.req_type <= jvmexe_pkg::OP_ASTORE_3)
      idx8 = in_data.req_type - jvmexe_pkg::OP_ASTORE_0;
    else
      idx8 = in_data.immediate[7:0];
  end

  assign lidx1 = ({1'b0, lidx_r} == (LW+1)'(LOCAL_SLOTS - 1)) ? '0 : lidx_r + LW'(1);

  assign s_raddr = AW'(sp_r - SPW'(1) - SPW'(rc_r));
  assign s_waddr = AW'(base_r + SPW'(wc_r));
  assign s_we    = (state_r == S_WR) && ({1'b0, wc_r} < npush_r);
  assign l_raddr = (rc_r == 3'd0) ? lidx_r : lidx1;
  assign l_waddr = wc_r[0] ? lidx1 : lidx_r;
  assign l_we    = (state_r == S_WR) && (wc_r < nlw_r);
  assign nwr     = (npush_r > {1'b0, nlw_r}) ? npush_r : {1'b0, nlw_r};

  always_ff @(posedge clk) begin
    if (s_we) smem[s_waddr] <= res_r[wc_r];
    srd_r <= smem[s_raddr];
    srv_r <= (SPW+1)'(rc_r) < (SPW+1)'(sp_r);
  end

  always_ff @(posedge clk) begin
    if (l_we) lmem[l_waddr] <= lwv_r[wc_r[0]];
    lrd_r <= lmem[l_raddr];
    lrv_r <= lvalid_r[l_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvalid_r <= '0;
    end else if (l_we) begin
      lvalid_r[l_waddr] <= 1'b1;
    end
  end

  assign a   = opnd_r[1];
  assign b   = opnd_r[0];
  assign la  = {opnd_r[3], opnd_r[2]};
  assign lb  = {opnd_r[1], opnd_r[0]};
  assign lsv = {opnd_r[2], opnd_r[1]};

  always_comb begin
    unsup   = 1'b0;
    npop    = 3'd0;
    npush   = 3'd0;
    nlw     = 2'd0;
    r[0]    = '0;
    r[1]    = '0;
    r[2]    = '0;
    r[3]    = '0;
    lr      = '0;
    lwv0    = b;
    lwv1    = b;
    isbr    = 1'b0;
    cond    = 1'b0;
    md_use  = 1'b0;
    md_op   = jvmexe_pkg::MD_MUL;
    md_long = 1'b0;
    unique case (op_r)
      jvmexe_pkg::OP_NOP: ;
      jvmexe_pkg::OP_ACONST_NULL: npush = 3'd1;
      jvmexe_pkg::OP_ICONST_M1, jvmexe_pkg::OP_ICONST_0, jvmexe_pkg::OP_ICONST_1,
      jvmexe_pkg::OP_ICONST_2, jvmexe_pkg::OP_ICONST_3, jvmexe_pkg::OP_ICONST_4,
      jvmexe_pkg::OP_ICONST_5: begin
        npush = 3'd1;
        r[0]  = {24'd0, op_r} - {24'd0, jvmexe_pkg::OP_ICONST_0};
      end
      jvmexe_pkg::OP_LCONST_0, jvmexe_pkg::OP_LCONST_1: begin
        npush = 3'd2;
        r[1]  = {24'd0, op_r} - {24'd0, jvmexe_pkg::OP_LCONST_0};
      end
      jvmexe_pkg::OP_BIPUSH: begin
        npush = 3'd1;
        r[0]  = {{24{imm_r[7]}}, imm_r[7:0]};
      end
      jvmexe_pkg::OP_SIPUSH: begin
        npush = 3'd1;
        r[0]  = {{16{imm_r[15]}}, imm_r};
      end
      jvmexe_pkg::OP_ILOAD, jvmexe_pkg::OP_ALOAD,
      jvmexe_pkg::OP_ILOAD_0, jvmexe_pkg::OP_ILOAD_1, jvmexe_pkg::OP_ILOAD_2,
      jvmexe_pkg::OP_ILOAD_3, jvmexe_pkg::OP_ALOAD_0, jvmexe_pkg::OP_ALOAD_1,
      jvmexe_pkg::OP_ALOAD_2, jvmexe_pkg::OP_ALOAD_3: begin
        npush = 3'd1;
        r[0]  = lcl0_r;
      end
      jvmexe_pkg::OP_LLOAD, jvmexe_pkg::OP_LLOAD_0, jvmexe_pkg::OP_LLOAD_1,
      jvmexe_pkg::OP_LLOAD_2, jvmexe_pkg::OP_LLOAD_3: begin
        npush = 3'd2;
        r[0]  = lcl0_r;
        r[1]  = lcl1_r;
      end
      jvmexe_pkg::OP_ISTORE, jvmexe_pkg::OP_ASTORE,
      jvmexe_pkg::OP_ISTORE_0, jvmexe_pkg::OP_ISTORE_1, jvmexe_pkg::OP_ISTORE_2,
      jvmexe_pkg::OP_ISTORE_3, jvmexe_pkg::OP_ASTORE_0, jvmexe_pkg::OP_ASTORE_1,
      jvmexe_pkg::OP_ASTORE_2, jvmexe_pkg::OP_ASTORE_3: begin
        npop = 3'd1;
        nlw  = 2'd1;
      end
      jvmexe_pkg::OP_LSTORE, jvmexe_pkg::OP_LSTORE_0, jvmexe_pkg::OP_LSTORE_1,
      jvmexe_pkg::OP_LSTORE_2, jvmexe_pkg::OP_LSTORE_3: begin
        npop = 3'd2;
        nlw  = 2'd2;
        lwv0 = a;
      end
      jvmexe_pkg::OP_POP:  npop = 3'd1;
      jvmexe_pkg::OP_POP2: npop = 3'd2;
      jvmexe_pkg::OP_DUP: begin
        npop  = 3'd1;
        npush = 3'd2;
        r[0]  = b;
        r[1]  = b;
      end
      jvmexe_pkg::OP_DUP2: begin
        npop  = 3'd2;
        npush = 3'd4;
        r[0]  = a;
        r[1]  = b;
        r[2]  = a;
        r[3]  = b;
      end
      jvmexe_pkg::OP_SWAP: begin
        npop  = 3'd2;
        npush = 3'd2;
        r[0]  = b;
        r[1]  = a;
      end
      jvmexe_pkg::OP_IADD: begin npop = 3'd2; npush = 3'd1; r[0] = a + b; end
      jvmexe_pkg::OP_ISUB: begin npop = 3'd2; npush = 3'd1; r[0] = a - b; end
      jvmexe_pkg::OP_IAND: begin npop = 3'd2; npush = 3'd1; r[0] = a & b; end
      jvmexe_pkg::OP_IOR:  begin npop = 3'd2; npush = 3'd1; r[0] = a | b; end
      jvmexe_pkg::OP_IXOR: begin npop = 3'd2; npush = 3'd1; r[0] = a ^ b; end
      jvmexe_pkg::OP_ISHL: begin npop = 3'd2; npush = 3'd1; r[0] = a << b[4:0]; end
      jvmexe_pkg::OP_ISHR: begin
        npop  = 3'd2;
        npush = 3'd1;
        r[0]  = $unsigned($signed(a) >>> b[4:0]);
      end
      jvmexe_pkg::OP_IUSHR: begin npop = 3'd2; npush = 3'd1; r[0] = a >> b[4:0]; end
      jvmexe_pkg::OP_IMUL: begin
        npop   = 3'd2;
        npush  = 3'd1;
        md_use = 1'b1;
      end
      jvmexe_pkg::OP_IDIV: begin
        npop   = 3'd2;
        npush  = 3'd1;
        md_use = 1'b1;
        md_op  = jvmexe_pkg::MD_DIV;
      end
      jvmexe_pkg::OP_IREM: begin
        npop   = 3'd2;
        npush  = 3'd1;
        md_use = 1'b1;
        md_op  = jvmexe_pkg::MD_REM;
      end
      jvmexe_pkg::OP_INEG: begin npop = 3'd1; npush = 3'd1; r[0] = 32'd0 - b; end
      jvmexe_pkg::OP_LADD, jvmexe_pkg::OP_LSUB, jvmexe_pkg::OP_LAND,
      jvmexe_pkg::OP_LOR, jvmexe_pkg::OP_LXOR: begin
        npop  = 3'd4;
        npush = 3'd2;
        unique case (op_r)
          jvmexe_pkg::OP_LADD: lr = la + lb;
          jvmexe_pkg::OP_LSUB: lr = la - lb;
          jvmexe_pkg::OP_LAND: lr = la & lb;
          jvmexe_pkg::OP_LOR:  lr = la | lb;
          default:             lr = la ^ lb;
        endcase
        r[0] = lr[63:32];
        r[1] = lr[31:0];
      end
      jvmexe_pkg::OP_LMUL, jvmexe_pkg::OP_LDIV, jvmexe_pkg::OP_LREM: begin
        npop    = 3'd4;
        npush   = 3'd2;
        md_use  = 1'b1;
        md_long = 1'b1;
        unique case (op_r)
          jvmexe_pkg::OP_LMUL: md_op = jvmexe_pkg::MD_MUL;
          jvmexe_pkg::OP_LDIV: md_op = jvmexe_pkg::MD_DIV;
          default:             md_op = jvmexe_pkg::MD_REM;
        endcase
      end
      jvmexe_pkg::OP_LNEG: begin
        npop  = 3'd2;
        npush = 3'd2;
        lr    = 64'd0 - lb;
        r[0]  = lr[63:32];
        r[1]  = lr[31:0];
      end
      jvmexe_pkg::OP_LSHL, jvmexe_pkg::OP_LSHR, jvmexe_pkg::OP_LUSHR: begin
        npop  = 3'd3;
        npush = 3'd2;
        unique case (op_r)
          jvmexe_pkg::OP_LSHL: lr = lsv << b[5:0];
          jvmexe_pkg::OP_LSHR: lr = $unsigned($signed(lsv) >>> b[5:0]);
          default:             lr = lsv >> b[5:0];
        endcase
        r[0] = lr[63:32];
        r[1] = lr[31:0];
      end
      jvmexe_pkg::OP_IINC: begin
        nlw  = 2'd1;
        lwv0 = lcl0_r + {{24{inc_r[7]}}, inc_r};
      end
      jvmexe_pkg::OP_I2L: begin
        npop  = 3'd1;
        npush = 3'd2;
        r[0]  = {32{b[31]}};
        r[1]  = b;
      end
      jvmexe_pkg::OP_L2I: begin npop = 3'd2; npush = 3'd1; r[0] = b; end
      jvmexe_pkg::OP_I2B: begin
        npop  = 3'd1;
        npush = 3'd1;
        r[0]  = {{24{b[7]}}, b[7:0]};
      end
      jvmexe_pkg::OP_I2C: begin npop = 3'd1; npush = 3'd1; r[0] = {16'd0, b[15:0]}; end
      jvmexe_pkg::OP_I2S: begin
        npop  = 3'd1;
        npush = 3'd1;
        r[0]  = {{16{b[15]}}, b[15:0]};
      end
      jvmexe_pkg::OP_LCMP: begin
        npop  = 3'd4;
        npush = 3'd1;
        if ($signed(la) > $signed(lb)) r[0] = 32'd1;
        else if (la == lb)             r[0] = 32'd0;
        else                           r[0] = 32'hFFFF_FFFF;
      end
      jvmexe_pkg::OP_IFEQ: begin npop = 3'd1; isbr = 1'b1; cond = (b == 32'd0); end
      jvmexe_pkg::OP_IFNE: begin npop = 3'd1; isbr = 1'b1; cond = (b != 32'd0); end
      jvmexe_pkg::OP_IFLT: begin npop = 3'd1; isbr = 1'b1; cond = b[31]; end
      jvmexe_pkg::OP_IFGE: begin npop = 3'd1; isbr = 1'b1; cond = !b[31]; end
      jvmexe_pkg::OP_IFGT: begin
        npop = 3'd1;
        isbr = 1'b1;
        cond = (b != 32'd0) && !b[31];
      end
      jvmexe_pkg::OP_IFLE: begin
        npop = 3'd1;
        isbr = 1'b1;
        cond = (b == 32'd0) || b[31];
      end
      jvmexe_pkg::OP_IF_ICMPEQ, jvmexe_pkg::OP_IF_ACMPEQ: begin
        npop = 3'd2;
        isbr = 1'b1;
        cond = (a == b);
      end
      jvmexe_pkg::OP_IF_ICMPNE, jvmexe_pkg::OP_IF_ACMPNE: begin
        npop = 3'd2;
        isbr = 1'b1;
        cond = (a != b);
      end
      jvmexe_pkg::OP_IF_ICMPLT: begin
        npop = 3'd2; isbr = 1'b1; cond = $signed(a) < $signed(b);
      end
      jvmexe_pkg::OP_IF_ICMPGE: begin
        npop = 3'd2; isbr = 1'b1; cond = !($signed(a) < $signed(b));
      end
      jvmexe_pkg::OP_IF_ICMPGT: begin
        npop = 3'd2; isbr = 1'b1; cond = $signed(b) < $signed(a);
      end
      jvmexe_pkg::OP_IF_ICMPLE: begin
        npop = 3'd2; isbr = 1'b1; cond = !($signed(b) < $signed(a));
      end
      jvmexe_pkg::OP_GOTO: begin isbr = 1'b1; cond = 1'b1; end
      default: unsup = 1'b1;
    endcase
  end

  assign dz = md_use && (md_op != jvmexe_pkg::MD_MUL) &&
              (md_long ? (lb == 64'd0) : (b == 32'd0));

  assign sp_after = (SPW+1)'(sp_r) - (SPW+1)'(npop) + (SPW+1)'(npush);
  assign fits     = ((SPW+1)'(sp_r) >= (SPW+1)'(npop)) &&
                    (sp_after <= (SPW+1)'(STACK_SLOTS));

  assign md_req.op = md_op;
  assign md_req.a  = md_long ? la : {{32{a[31]}}, a};
  assign md_req.b  = md_long ? lb : {{32{b[31]}}, b};
  assign md_start  = (state_r == S_EX) && !unsup && fits && md_use && !dz;

  jvmexe_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (md_start),
    .req    (md_req),
    .busy   (md_busy),
    .done   (md_done),
    .result (md_res)
  );

  assign top      = (npush_r != 3'd0) ? res_r[2'(npush_r - 3'd1)] : opnd_r[npop_r[1:0]];
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_data.req_type;
            imm_r   <= in_data.immediate;
            inc_r   <= in_data.increment;
            lidx_r  <= mod_tab[idx8];
            rc_r    <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          if (rc_r != 3'd0) opnd_r[2'(rc_r - 3'd1)] <= srv_r ? srd_r : 32'd0;
          if (rc_r == 3'd1) lcl0_r <= lrv_r ? lrd_r : 32'd0;
          if (rc_r == 3'd2) lcl1_r <= lrv_r ? lrd_r : 32'd0;
          if (rc_r == 3'd4) state_r <= S_EX;
          else rc_r <= rc_r + 3'd1;
        end
        S_EX: begin
          wc_r      <= '0;
          md_long_r <= md_long;
          nlw_r     <= nlw;
          lwv_r[0]  <= lwv0;
          lwv_r[1]  <= lwv1;
          for (int i = 0; i < 4; i++) res_r[i] <= dz ? 32'd0 : r[i];
          if (unsup || !fits) begin
            status_r <= unsup ? jvmexe_pkg::ST_UNSUP : jvmexe_pkg::ST_FAULT;
            npop_r   <= '0;
            npush_r  <= '0;
            taken_r  <= 1'b0;
            state_r  <= S_OUT;
          end else begin
            status_r <= dz ? jvmexe_pkg::ST_DIVZERO : jvmexe_pkg::ST_OK;
            npop_r   <= npop;
            npush_r  <= npush;
            taken_r  <= isbr && cond;
            base_r   <= sp_r - SPW'(npop);
            sp_r     <= SPW'(sp_after);
            state_r  <= (md_use && !dz) ? S_MD : S_WR;
          end
        end
        S_MD: begin
          if (md_done) begin
            res_r[0] <= md_long_r ? md_res[63:32] : md_res[31:0];
            res_r[1] <= md_res[31:0];
            state_r  <= S_WR;
          end
        end
        S_WR: begin
          if ({1'b0, wc_r} + 3'd1 >= nwr) state_r <= S_OUT;
          else wc_r <= wc_r + 2'd1;
        end
        S_OUT: begin
          if (out_load) begin
            out_r.status        <= status_r;
            out_r.branch_taken  <= taken_r;
            out_r.branch_offset <= taken_r ? imm_r : 16'd0;
            out_r.stack_depth   <= 7'(sp_r);
            out_r.top_value     <= top;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (SPW+1)'(sp_r) <= (SPW+1)'(STACK_SLOTS))
    else $error("stack pointer beyond capacity");

  a_md_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (md_busy || md_done) |-> state_r == S_MD)
    else $error("multiply/divide unit active outside its wait state");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_ready) |=> state_r == S_OUT)
    else $error("result overwritten while the output register is full");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == jvmexe_pkg::ST_DIVZERO) |-> out_r.top_value == 32'sd0)
    else $error("divide by zero did not leave zero on top");

  a_no_write_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (s_we || l_we) |-> status_r == jvmexe_pkg::ST_OK || status_r == jvmexe_pkg::ST_DIVZERO)
    else $error("state written by a faulting instruction");

endmodule

/* tb/jvm_integer_bytecode_execute_core_checker.sv */
// Checker for the JVM execute core: predicts each result and compares it.
`timescale 1ns / 1ps

module jvm_integer_bytecode_execute_core_checker
  import jvmexe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        errors,
  output int        pending,
  output int        checked
);

  logic [31:0] stack_mem [STACK_SLOTS_DEF];
  logic [31:0] locals    [LOCAL_SLOTS_DEF];
  int          depth;
  out_item_t   expected_results[$];

  function automatic logic [31:0] peek(int k);
    if (k < depth) return stack_mem[depth - 1 - k];
    return 32'd0;
  endfunction

  function automatic logic [31:0] sx8(logic [31:0] v);
    return {{24{v[7]}}, v[7:0]};
  endfunction

  function automatic logic [31:0] sx16(logic [31:0] v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

  function automatic out_item_t execute_instr(in_item_t it);
    logic [7:0]  op;
    logic [31:0] imm, a, b;
    logic [31:0] res [4];
    logic [31:0] lwv [2];
    int          lwi [2];
    logic [63:0] la, lb, lr;
    int          npop, npush, nlw, idx;
    logic [1:0]  st;
    logic        isbr, cond, dz, taken;
    out_item_t   o;
    op = it.req_type;
    imm = sx16({16'd0, it.immediate});
    idx = it.immediate[7:0];
    a = peek(1);
    b = peek(0);
    la = {peek(3), peek(2)};
    lb = {peek(1), peek(0)};
    lr = '0;
    res = '{default: 32'd0};
    lwv = '{default: 32'd0};
    lwi = '{default: 0};
    npop = 0; npush = 0; nlw = 0;
    st = ST_OK; isbr = 0; cond = 0; dz = 0;
    case (op)
      OP_NOP: ;
      OP_ACONST_NULL: begin npush = 1; end
      OP_ICONST_M1, OP_ICONST_0, OP_ICONST_1, OP_ICONST_2, OP_ICONST_3, OP_ICONST_4,
      OP_ICONST_5: begin npush = 1; res[0] = 32'(op) - 32'(OP_ICONST_0); end
      OP_LCONST_0, OP_LCONST_1: begin npush = 2; res[1] = 32'(op) - 32'(OP_LCONST_0); end
      OP_BIPUSH: begin npush = 1; res[0] = sx8(imm); end
      OP_SIPUSH: begin npush = 1; res[0] = imm; end
      OP_ILOAD, OP_ALOAD: begin npush = 1; res[0] = locals[idx]; end
      OP_ILOAD_0, OP_ILOAD_1, OP_ILOAD_2, OP_ILOAD_3: begin
        npush = 1; res[0] = locals[op - OP_ILOAD_0];
      end
      OP_ALOAD_0, OP_ALOAD_1, OP_ALOAD_2, OP_ALOAD_3: begin
        npush = 1; res[0] = locals[op - OP_ALOAD_0];
      end
      OP_LLOAD, OP_LLOAD_0, OP_LLOAD_1, OP_LLOAD_2, OP_LLOAD_3: begin
        if (op != OP_LLOAD) idx = op - OP_LLOAD_0;
        npush = 2; res[0] = locals[idx]; res[1] = locals[(idx + 1) % LOCAL_SLOTS_DEF];
      end
      OP_ISTORE, OP_ASTORE, OP_ISTORE_0, OP_ISTORE_1, OP_ISTORE_2, OP_ISTORE_3,
      OP_ASTORE_0, OP_ASTORE_1, OP_ASTORE_2, OP_ASTORE_3: begin
        if (op >= OP_ASTORE_0) idx = op - OP_ASTORE_0;
        else if (op >= OP_ISTORE_0) idx = op - OP_ISTORE_0;
        npop = 1; nlw = 1; lwi[0] = idx; lwv[0] = b;
      end
      OP_LSTORE, OP_LSTORE_0, OP_LSTORE_1, OP_LSTORE_2, OP_LSTORE_3: begin
        if (op != OP_LSTORE) idx = op - OP_LSTORE_0;
        npop = 2; nlw = 2; lwi[0] = idx; lwv[0] = a;
        lwi[1] = (idx + 1) % LOCAL_SLOTS_DEF; lwv[1] = b;
      end
      OP_POP: npop = 1;
      OP_POP2: npop = 2;
      OP_DUP: begin npop = 1; npush = 2; res[0] = b; res[1] = b; end
      OP_DUP2: begin
        npop = 2; npush = 4; res[0] = a; res[1] = b; res[2] = a; res[3] = b;
      end
      OP_SWAP: begin npop = 2; npush = 2; res[0] = b; res[1] = a; end
      OP_IADD: begin npop = 2; npush = 1; res[0] = a + b; end
      OP_ISUB: begin npop = 2; npush = 1; res[0] = a - b; end
      OP_IMUL: begin npop = 2; npush = 1; res[0] = a * b; end
      OP_IDIV, OP_IREM: begin
        npop = 2; npush = 1;
        if (b == 0) dz = 1;
        else if (b == 32'hFFFF_FFFF) res[0] = (op == OP_IDIV) ? 32'd0 - a : 32'd0;
        else if (op == OP_IDIV) res[0] = $signed(a) / $signed(b);
        else res[0] = $signed(a) % $signed(b);
      end
      OP_INEG: begin npop = 1; npush = 1; res[0] = 32'd0 - b; end
      OP_ISHL: begin npop = 2; npush = 1; res[0] = a << b[4:0]; end
      OP_ISHR: begin npop = 2; npush = 1; res[0] = $signed(a) >>> b[4:0]; end
      OP_IUSHR: begin npop = 2; npush = 1; res[0] = a >> b[4:0]; end
      OP_IAND: begin npop = 2; npush = 1; res[0] = a & b; end
      OP_IOR: begin npop = 2; npush = 1; res[0] = a | b; end
      OP_IXOR: begin npop = 2; npush = 1; res[0] = a ^ b; end
      OP_LADD, OP_LSUB, OP_LMUL, OP_LDIV, OP_LREM, OP_LAND, OP_LOR, OP_LXOR: begin
        npop = 4; npush = 2;
        case (op)
          OP_LADD: lr = la + lb;
          OP_LSUB: lr = la - lb;
          OP_LMUL: lr = la * lb;
          OP_LAND: lr = la & lb;
          OP_LOR:  lr = la | lb;
          OP_LXOR: lr = la ^ lb;
          default: begin
            if (lb == 0) dz = 1;
            else if (lb == '1) lr = (op == OP_LDIV) ? 64'd0 - la : 64'd0;
            else if (op == OP_LDIV) lr = $signed(la) / $signed(lb);
            else lr = $signed(la) % $signed(lb);
          end
        endcase
        res[0] = lr[63:32]; res[1] = lr[31:0];
      end
      OP_LNEG: begin
        npop = 2; npush = 2; lr = 64'd0 - lb; res[0] = lr[63:32]; res[1] = lr[31:0];
      end
      OP_LSHL, OP_LSHR, OP_LUSHR: begin
        npop = 3; npush = 2;
        lr = {peek(2), a};
        if (op == OP_LSHL) lr = lr << b[5:0];
        else if (op == OP_LSHR) lr = $signed(lr) >>> b[5:0];
        else lr = lr >> b[5:0];
        res[0] = lr[63:32]; res[1] = lr[31:0];
      end
      OP_IINC: begin nlw = 1; lwi[0] = idx; lwv[0] = locals[idx] + sx8({24'd0, it.increment}); end
      OP_I2L: begin npop = 1; npush = 2; res[0] = {32{b[31]}}; res[1] = b; end
      OP_L2I: begin npop = 2; npush = 1; res[0] = b; end
      OP_I2B: begin npop = 1; npush = 1; res[0] = sx8(b); end
      OP_I2C: begin npop = 1; npush = 1; res[0] = {16'd0, b[15:0]}; end
      OP_I2S: begin npop = 1; npush = 1; res[0] = sx16(b); end
      OP_LCMP: begin
        npop = 4; npush = 1;
        res[0] = ($signed(la) > $signed(lb)) ? 32'd1 : (la == lb) ? 32'd0 : 32'hFFFF_FFFF;
      end
      OP_IFEQ: begin npop = 1; isbr = 1; cond = (b == 0); end
      OP_IFNE: begin npop = 1; isbr = 1; cond = (b != 0); end
      OP_IFLT: begin npop = 1; isbr = 1; cond = b[31]; end
      OP_IFGE: begin npop = 1; isbr = 1; cond = !b[31]; end
      OP_IFGT: begin npop = 1; isbr = 1; cond = (b != 0) && !b[31]; end
      OP_IFLE: begin npop = 1; isbr = 1; cond = (b == 0) || b[31]; end
      OP_IF_ICMPEQ, OP_IF_ACMPEQ: begin npop = 2; isbr = 1; cond = (a == b); end
      OP_IF_ICMPNE, OP_IF_ACMPNE: begin npop = 2; isbr = 1; cond = (a != b); end
      OP_IF_ICMPLT: begin npop = 2; isbr = 1; cond = $signed(a) < $signed(b); end
      OP_IF_ICMPGE: begin npop = 2; isbr = 1; cond = $signed(a) >= $signed(b); end
      OP_IF_ICMPGT: begin npop = 2; isbr = 1; cond = $signed(a) > $signed(b); end
      OP_IF_ICMPLE: begin npop = 2; isbr = 1; cond = $signed(a) <= $signed(b); end
      OP_GOTO: begin isbr = 1; cond = 1; end
      default: st = ST_UNSUP;
    endcase
    taken = 0;
    if (st == ST_OK) begin
      if (depth < npop || depth - npop + npush > STACK_SLOTS_DEF) begin
        st = ST_FAULT;
      end else begin
        depth -= npop;
        for (int i = 0; i < npush; i++) begin
          stack_mem[depth] = dz ? 32'd0 : res[i];
          depth++;
        end
        for (int i = 0; i < nlw; i++) locals[lwi[i]] = lwv[i];
        if (dz) st = ST_DIVZERO;
        taken = isbr && cond;
      end
    end
    o.status = st;
    o.branch_taken = taken;
    o.branch_offset = taken ? it.immediate : 16'sd0;
    o.stack_depth = 7'(depth);
    o.top_value = peek(0);
    return o;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      depth = 0;
      foreach (locals[i]) locals[i] = 32'd0;
      foreach (stack_mem[i]) stack_mem[i] = 32'd0;
      expected_results.delete();
      errors <= 0;
      checked <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected");
          errors <= errors + 1;
        end else begin
          e = expected_results.pop_front();
          checked <= checked + 1;
          if (out_data !== e) begin
            errors <= errors + 1;
            if (out_data.status !== e.status)
              $error("status: expected %0d, got %0d", e.status, out_data.status);
            if (out_data.branch_taken !== e.branch_taken)
              $error("branch_taken: expected %0d, got %0d", e.branch_taken,
                     out_data.branch_taken);
            if (out_data.branch_offset !== e.branch_offset)
              $error("branch_offset: expected %0d, got %0d", e.branch_offset,
                     out_data.branch_offset);
            if (out_data.stack_depth !== e.stack_depth)
              $error("stack_depth: expected %0d, got %0d", e.stack_depth,
                     out_data.stack_depth);
            if (out_data.top_value !== e.top_value)
              $error("top_value: expected %h, got %h", e.top_value, out_data.top_value);
          end
        end
      end
      if (in_valid && in_ready) expected_results = {expected_results, execute_instr(in_data)};
    end
  end

endmodule

/* tb/jvm_integer_bytecode_execute_core_test.sv */
// Top of the JVM execute core testbench: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module jvm_integer_bytecode_execute_core_test;
  import jvmexe_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int STALL_LIMIT  = 5000;

  localparam logic [7:0] GROW_OPS [20] = '{
    OP_ACONST_NULL, OP_ICONST_M1, OP_ICONST_0, OP_ICONST_1, OP_ICONST_5, OP_LCONST_0,
    OP_LCONST_1, OP_BIPUSH, OP_SIPUSH, OP_ILOAD, OP_LLOAD, OP_ALOAD, OP_ILOAD_2,
    OP_LLOAD_1, OP_ALOAD_3, OP_DUP, OP_DUP2, OP_I2L, OP_NOP, OP_GOTO};
  localparam logic [7:0] SHRINK_OPS [60] = '{
    OP_ISTORE, OP_LSTORE, OP_ASTORE, OP_ISTORE_0, OP_ISTORE_1, OP_ISTORE_2, OP_ISTORE_3,
    OP_LSTORE_0, OP_LSTORE_1, OP_LSTORE_2, OP_LSTORE_3, OP_ASTORE_0, OP_ASTORE_1,
    OP_ASTORE_2, OP_ASTORE_3, OP_POP, OP_POP2, OP_SWAP, OP_IADD, OP_LADD, OP_ISUB,
    OP_LSUB, OP_IMUL, OP_LMUL, OP_IDIV, OP_LDIV, OP_IREM, OP_LREM, OP_INEG, OP_LNEG,
    OP_ISHL, OP_LSHL, OP_ISHR, OP_LSHR, OP_IUSHR, OP_LUSHR, OP_IAND, OP_LAND, OP_IOR,
    OP_LOR, OP_IXOR, OP_LXOR, OP_IINC, OP_L2I, OP_I2B, OP_I2C, OP_I2S, OP_LCMP,
    OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGE, OP_IFGT, OP_IFLE, OP_IF_ICMPEQ, OP_IF_ICMPNE,
    OP_IF_ICMPLT, OP_IF_ICMPGE, OP_IF_ICMPGT, OP_IF_ICMPLE};
  localparam logic [7:0] MISC_OPS [8] = '{
    OP_IF_ACMPEQ, OP_IF_ACMPNE, OP_ILOAD_0, OP_ILOAD_1, OP_ILOAD_3, OP_LLOAD_0,
    OP_LLOAD_2, OP_LLOAD_3};

  logic      clk, rst_n;
  logic      in_valid, in_ready, out_valid, out_ready;
  in_item_t  in_data;
  out_item_t out_data;
  int        errors, pending, checked;
  int        sent, idle_cycles;
  logic      quiet, hold_out;

  jvm_integer_bytecode_execute_core dut (.*);

  jvm_integer_bytecode_execute_core_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .errors, .pending, .checked
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic send(logic [7:0] op, logic [15:0] imm, logic [7:0] inc);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_data = '{req_type: op, immediate: imm, increment: inc};
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  initial begin
    int g;
    bit held;
    out_ready = 0;
    held = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_out && !held) begin
        out_ready = 0;
        repeat (400) @(negedge clk);
        held = 1;
      end
      g = quiet ? 0 : $urandom_range(0, 5);
      if (g > 0) begin
        out_ready = 0;
        repeat (g) @(negedge clk);
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [7:0]  op;
    logic [15:0] imm;
    bit          grow;
    int          pick;
    rst_n = 0; in_valid = 0; in_data = '0; quiet = 0; hold_out = 0; sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // arithmetic corner cases, faults and local index wrap
    send(OP_NOP, 16'd0, 8'd0);
    send(OP_POP, 16'd0, 8'd0);
    send(8'hFF, 16'hFFFF, 8'hFF);
    send(OP_ICONST_1, 16'd0, 8'd0);
    send(OP_BIPUSH, 16'd31, 8'd0);
    send(OP_ISHL, 16'd0, 8'd0);
    send(OP_ICONST_M1, 16'd0, 8'd0);
    send(OP_IDIV, 16'd0, 8'd0);
    send(OP_ICONST_M1, 16'd0, 8'd0);
    send(OP_IREM, 16'd0, 8'd0);
    send(OP_ICONST_0, 16'd0, 8'd0);
    send(OP_IDIV, 16'd0, 8'd0);
    send(OP_POP, 16'd0, 8'd0);
    send(OP_LCONST_1, 16'd0, 8'd0);
    send(OP_BIPUSH, 16'h00FF, 8'd0);
    send(OP_LSHL, 16'd0, 8'd0);
    send(OP_ICONST_M1, 16'd0, 8'd0);
    send(OP_I2L, 16'd0, 8'd0);
    send(OP_LDIV, 16'd0, 8'd0);
    send(OP_LCONST_0, 16'd0, 8'd0);
    send(OP_LREM, 16'd0, 8'd0);
    send(OP_SIPUSH, 16'h8000, 8'd0);
    send(OP_ISTORE, 16'h00FF, 8'd0);
    send(OP_LSTORE, 16'hFFFF, 8'd0);
    send(OP_IINC, 16'h00FF, 8'h80);
    send(OP_LLOAD, 16'h00FF, 8'h7F);
    send(OP_GOTO, 16'h8000, 8'd0);

    grow = 1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) grow = 1'($urandom_range(0, 1));
      if (n % 150 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_ITEMS / 2) hold_out = 1;
      pick = $urandom_range(0, 99);
      if (pick < 5) op = 8'($urandom_range(0, 255));
      else if (pick < 10) op = MISC_OPS[3'($urandom_range(0, 7))];
      else if (grow ? pick < 75 : pick < 35) op = GROW_OPS[5'($urandom_range(0, 19))];
      else op = SHRINK_OPS[6'($urandom_range(0, 59))];
      imm = ($urandom_range(0, 9) < 4) ? 16'($urandom_range(0, 7)) : 16'($urandom());
      send(op, imm, 8'($urandom()));
    end
    in_valid = 0;

    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("Ran %0d instructions through the core, %0d results checked, %0d errors.",
             sent, checked, errors);
    $display("Covered stack faults at both ends, divide by zero and long/int corner math.");
    if (errors == 0 && pending == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
src/jvmexe_pkg.sv
src/jvmexe_muldiv.sv
src/jvm_integer_bytecode_execute_core.sv
tb/jvm_integer_bytecode_execute_core_checker.sv
tb/jvm_integer_bytecode_execute_core_test.sv
